// ===== rtl/cs4bc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs4bc_pkg - shared types and constants
// Widths, reset values, register indexes and the control state type for the
// circulant strength-4 balance check.
// ----------------------------------------------------------------------------
package cs4bc_pkg;

    localparam int DEF_MAX_LEN  = 24;
    localparam int DEF_MAX_ROWS = 12;

    localparam int IN_W      = 24;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_W     = 5;
    localparam int LEN_REG_W = 5;
    localparam int ROW_REG_W = 4;
    localparam int SUBSET_SIZE = 4;
    localparam int TUPLES    = 16;

    localparam logic [LEN_REG_W-1:0] LEN_RESET = 5'd8;
    localparam logic [ROW_REG_W-1:0] ROW_RESET = 4'd10;

    typedef enum logic {
        REG_VECTOR_LENGTH = 1'b0,
        REG_ROW_COUNT     = 1'b1
    } t_reg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic issue;
        logic last;
    } t_seq_ctl;

    typedef struct packed {
        logic valid;
        logic ok;
        logic busy;
    } t_chk_status;

endpackage

// ===== rtl/cs4bc_subset_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs4bc_subset_seq - 4-subset sequencer
// Walks all row subsets a<b<c<d in lexicographic order, one per cycle, and
// keeps the four rotated rows in step by single-position rotations.
// ----------------------------------------------------------------------------
module cs4bc_subset_seq #(
    parameter int MAX_LEN  = cs4bc_pkg::DEF_MAX_LEN,
    parameter int MAX_ROWS = cs4bc_pkg::DEF_MAX_ROWS,
    parameter int LW       = $clog2(MAX_LEN + 1),
    parameter int RW       = $clog2(MAX_ROWS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MAX_LEN-1:0]  i_vec,
    input  logic [LW-1:0]       i_len,
    input  logic [RW-1:0]       i_rows,
    output cs4bc_pkg::t_seq_ctl o_ctl,
    output logic [MAX_LEN-1:0]  o_ra,
    output logic [MAX_LEN-1:0]  o_rb,
    output logic [MAX_LEN-1:0]  o_rc,
    output logic [MAX_LEN-1:0]  o_rd
);

    function automatic logic [MAX_LEN-1:0] rot1(input logic [MAX_LEN-1:0] x,
                                                input logic [LW-1:0] len);
        logic [MAX_LEN-1:0] y;
        y = '0;
        for (int j = 0; j < MAX_LEN; j++) begin
            if (len != '0 && int'(len) - 1 == j) begin
                y[j] = x[0];
            end else if (j < MAX_LEN - 1) begin
                y[j] = x[(j + 1) % MAX_LEN];
            end else begin
                y[j] = 1'b0;
            end
        end
        return y;
    endfunction

    logic               r_active;
    logic [LW-1:0]      r_len;
    logic [RW-1:0]      r_k;
    logic [RW-1:0]      r_a, r_b, r_c, r_d;
    logic [MAX_LEN-1:0] r_ra, r_rb, r_rc, r_rd;

    logic               w_adv_d, w_adv_c, w_adv_b, w_adv_a, w_last;
    logic [MAX_LEN-1:0] w_s1, w_s2, w_s3;
    logic [MAX_LEN-1:0] w_c1, w_c2, w_b1, w_b2, w_b3, w_a1, w_a2, w_a3, w_a4;

    always_comb begin
        w_adv_d = int'(r_d) + 1 < int'(r_k);
        w_adv_c = int'(r_c) + 2 < int'(r_k);
        w_adv_b = int'(r_b) + 3 < int'(r_k);
        w_adv_a = int'(r_a) + 4 < int'(r_k);
        w_last  = !w_adv_d && !w_adv_c && !w_adv_b && !w_adv_a;

        w_s1 = rot1(i_vec, i_len);
        w_s2 = rot1(w_s1, i_len);
        w_s3 = rot1(w_s2, i_len);

        w_c1 = rot1(r_rc, r_len);
        w_c2 = rot1(w_c1, r_len);
        w_b1 = rot1(r_rb, r_len);
        w_b2 = rot1(w_b1, r_len);
        w_b3 = rot1(w_b2, r_len);
        w_a1 = rot1(r_ra, r_len);
        w_a2 = rot1(w_a1, r_len);
        w_a3 = rot1(w_a2, r_len);
        w_a4 = rot1(w_a3, r_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_start) begin
            r_active <= 1'b1;
        end else if (r_active && w_last) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_len <= i_len;
            r_k   <= i_rows;
            r_a   <= RW'(0);
            r_b   <= RW'(1);
            r_c   <= RW'(2);
            r_d   <= RW'(3);
            r_ra  <= i_vec;
            r_rb  <= w_s1;
            r_rc  <= w_s2;
            r_rd  <= w_s3;
        end else if (r_active) begin
            if (w_adv_d) begin
                r_d  <= r_d + 1'b1;
                r_rd <= rot1(r_rd, r_len);
            end else if (w_adv_c) begin
                r_c  <= r_c + 1'b1;
                r_d  <= r_c + RW'(2);
                r_rc <= w_c1;
                r_rd <= w_c2;
            end else if (w_adv_b) begin
                r_b  <= r_b + 1'b1;
                r_c  <= r_b + RW'(2);
                r_d  <= r_b + RW'(3);
                r_rb <= w_b1;
                r_rc <= w_b2;
                r_rd <= w_b3;
            end else if (w_adv_a) begin
                r_a  <= r_a + 1'b1;
                r_b  <= r_a + RW'(2);
                r_c  <= r_a + RW'(3);
                r_d  <= r_a + RW'(4);
                r_ra <= w_a1;
                r_rb <= w_a2;
                r_rc <= w_a3;
                r_rd <= w_a4;
            end
        end
    end

    assign o_ctl.issue = r_active;
    assign o_ctl.last  = w_last;
    assign o_ra = r_ra;
    assign o_rb = r_rb;
    assign o_rc = r_rc;
    assign o_rd = r_rd;

endmodule

// ===== rtl/cs4bc_hist_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs4bc_hist_check - tuple histogram and spread check
// Three-stage unit: 16 column-parallel tuple counts, grouped min/max, then
// final min/max and the spread-at-most-one test. Takes one subset per cycle.
// ----------------------------------------------------------------------------
module cs4bc_hist_check #(
    parameter int MAX_LEN = cs4bc_pkg::DEF_MAX_LEN,
    parameter int CW      = $clog2(MAX_LEN + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [MAX_LEN-1:0]     i_ra,
    input  logic [MAX_LEN-1:0]     i_rb,
    input  logic [MAX_LEN-1:0]     i_rc,
    input  logic [MAX_LEN-1:0]     i_rd,
    input  logic [MAX_LEN-1:0]     i_mask,
    output cs4bc_pkg::t_chk_status o_status
);

    localparam int NT = cs4bc_pkg::TUPLES;
    localparam int NG = 4;

    logic          r_v1, r_v2, r_v3;
    logic [CW-1:0] r_cnt  [NT];
    logic [CW-1:0] r_gmin [NG];
    logic [CW-1:0] r_gmax [NG];
    logic          r_ok;

    logic [CW-1:0] n_cnt  [NT];
    logic [CW-1:0] n_gmin [NG];
    logic [CW-1:0] n_gmax [NG];
    logic [CW-1:0] w_min, w_max;
    logic          n_ok;

    always_comb begin
        logic [MAX_LEN-1:0] m;
        logic [3:0]         t;
        for (int i = 0; i < NT; i++) begin
            t = 4'(i);
            m = ~(i_ra ^ {MAX_LEN{t[3]}}) & ~(i_rb ^ {MAX_LEN{t[2]}}) &
                ~(i_rc ^ {MAX_LEN{t[1]}}) & ~(i_rd ^ {MAX_LEN{t[0]}}) & i_mask;
            n_cnt[i] = CW'($countones(m));
        end
    end

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_gmin[g] = r_cnt[g*NG];
            n_gmax[g] = r_cnt[g*NG];
            for (int e = 1; e < NG; e++) begin
                if (r_cnt[g*NG+e] < n_gmin[g]) n_gmin[g] = r_cnt[g*NG+e];
                if (r_cnt[g*NG+e] > n_gmax[g]) n_gmax[g] = r_cnt[g*NG+e];
            end
        end
    end

    always_comb begin
        w_min = r_gmin[0];
        w_max = r_gmax[0];
        for (int g = 1; g < NG; g++) begin
            if (r_gmin[g] < w_min) w_min = r_gmin[g];
            if (r_gmax[g] > w_max) w_max = r_gmax[g];
        end
        n_ok = (w_max - w_min) <= CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_gmin <= n_gmin;
        r_gmax <= n_gmax;
        r_ok   <= n_ok;
    end

    assign o_status.valid = r_v3;
    assign o_status.ok    = r_ok;
    assign o_status.busy  = r_v1 | r_v2 | r_v3;

endmodule

// ===== rtl/circulant_strength4_balance_check_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circulant_strength4_balance_check_unit - strength-4 balance check
// The sequencer walks the 4-row subsets of the k effective rows (none when
// k < 4), one subset per cycle through the shared histogram unit. A new item
// is accepted only after the previous result has been loaded into the output
// register, which waits while a previous result is untaken. Reset (synchronous,
// active low) clears control and loads vector_length = 8 and row_count = 10.
// ----------------------------------------------------------------------------
module circulant_strength4_balance_check_unit #(
    parameter int MAX_LEN  = cs4bc_pkg::DEF_MAX_LEN,
    parameter int MAX_ROWS = cs4bc_pkg::DEF_MAX_ROWS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [cs4bc_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [23:0] candidate_vector
    input  logic [cs4bc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] balanced, [7:1] zero
    output logic [cs4bc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    cs4bc_pkg::t_state                 r_state, n_state;
    logic [cs4bc_pkg::LEN_REG_W-1:0]   r_vector_length;
    logic [cs4bc_pkg::ROW_REG_W-1:0]   r_row_count;
    logic [MAX_LEN-1:0]                r_mask;
    logic                              r_ok, n_ok;
    logic                              r_out_valid, n_out_valid;
    logic                              r_out_bal, n_out_bal;

    logic [LW-1:0]          w_len;
    logic [RW-1:0]          w_rows;
    logic [MAX_LEN-1:0]     w_mask, w_vec;
    logic                   w_accept, w_start;
    cs4bc_pkg::t_seq_ctl    w_seq_ctl;
    cs4bc_pkg::t_chk_status w_chk;
    logic [MAX_LEN-1:0]     w_ra, w_rb, w_rc, w_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_length <= cs4bc_pkg::LEN_RESET;
            r_row_count     <= cs4bc_pkg::ROW_RESET;
        end else if (i_cfg_we) begin
            case (cs4bc_pkg::t_reg_index'(i_cfg_index))
                cs4bc_pkg::REG_VECTOR_LENGTH: begin
                    r_vector_length <= i_cfg_data[cs4bc_pkg::LEN_REG_W-1:0];
                end
                cs4bc_pkg::REG_ROW_COUNT: begin
                    r_row_count <= i_cfg_data[cs4bc_pkg::ROW_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_len  = (int'(r_vector_length) > MAX_LEN) ? LW'(MAX_LEN) : LW'(r_vector_length);
        w_rows = (int'(r_row_count) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(r_row_count);
        for (int j = 0; j < MAX_LEN; j++) begin
            w_mask[j] = j < int'(w_len);
            w_vec[j]  = (j < cs4bc_pkg::IN_W) ?
                        i_s_axis_tdata[j % cs4bc_pkg::IN_W] & w_mask[j] : 1'b0;
        end
    end

    assign o_s_axis_tready = (r_state == cs4bc_pkg::ST_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_start  = w_accept && int'(w_rows) >= cs4bc_pkg::SUBSET_SIZE;

    cs4bc_subset_seq #(
        .MAX_LEN (MAX_LEN),
        .MAX_ROWS(MAX_ROWS),
        .LW      (LW),
        .RW      (RW)
    ) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_vec  (w_vec),
        .i_len  (w_len),
        .i_rows (w_rows),
        .o_ctl  (w_seq_ctl),
        .o_ra   (w_ra),
        .o_rb   (w_rb),
        .o_rc   (w_rc),
        .o_rd   (w_rd)
    );

    cs4bc_hist_check #(
        .MAX_LEN(MAX_LEN),
        .CW     (LW)
    ) u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_seq_ctl.issue),
        .i_ra    (w_ra),
        .i_rb    (w_rb),
        .i_rc    (w_rc),
        .i_rd    (w_rd),
        .i_mask  (r_mask),
        .o_status(w_chk)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mask <= w_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cs4bc_pkg::ST_IDLE;
            r_ok        <= 1'b1;
            r_out_valid <= 1'b0;
            r_out_bal   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ok        <= n_ok;
            r_out_valid <= n_out_valid;
            r_out_bal   <= n_out_bal;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out_bal   = r_out_bal;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_chk.valid && !w_chk.ok) begin
            n_ok = 1'b0;
        end
        case (r_state)
            cs4bc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_ok    = 1'b1;
                    n_state = w_start ? cs4bc_pkg::ST_RUN : cs4bc_pkg::ST_DONE;
                end
            end
            cs4bc_pkg::ST_RUN: begin
                if (w_seq_ctl.issue && w_seq_ctl.last) begin
                    n_state = cs4bc_pkg::ST_DRAIN;
                end
            end
            cs4bc_pkg::ST_DRAIN: begin
                if (!w_chk.busy) begin
                    n_state = cs4bc_pkg::ST_DONE;
                end
            end
            cs4bc_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_bal   = r_ok;
                    n_state     = cs4bc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cs4bc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(cs4bc_pkg::OUT_TDATA_W-1){1'b0}}, r_out_bal};

endmodule

// ===== test/circulant_strength4_balance_check_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circulant_strength4_balance_check_unit_tb - strength-4 balance check bench
// Feeds candidate vectors through the input stream under several length and
// row settings. A behavioral predictor computes the balanced flag for every
// accepted item, and the output stream is checked against it in order.
// Both sides idle at random.
// ----------------------------------------------------------------------------
module circulant_strength4_balance_check_unit_tb;

    localparam int LEN_CAP        = cs4bc_pkg::DEF_MAX_LEN;
    localparam int ROW_CAP        = cs4bc_pkg::DEF_MAX_ROWS;
    localparam int IN_W           = cs4bc_pkg::IN_W;
    localparam int IN_TDATA_W     = cs4bc_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W    = cs4bc_pkg::OUT_TDATA_W;
    localparam int CFG_W          = cs4bc_pkg::CFG_W;
    localparam int LEN_REG_W      = cs4bc_pkg::LEN_REG_W;
    localparam int ROW_REG_W      = cs4bc_pkg::ROW_REG_W;
    localparam int TUPLES         = cs4bc_pkg::TUPLES;
    localparam int RANDOM_ITEMS   = 1200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 600;
    localparam int TIMEOUT_CYCLES = 5000000;

    typedef enum logic [1:0] {
        PEND_ITEM,
        PEND_CFG,
        PEND_DRAIN
    } t_pend_kind;

    typedef struct {
        t_pend_kind            kind;
        cs4bc_pkg::t_reg_index reg_idx;
        logic [CFG_W-1:0]      value;
        logic [IN_W-1:0]       vector;
    } t_pend;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic                    i_cfg_index = 1'b0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;

    t_pend                   pending_q[$];
    logic                    balance_exp_q[$];
    logic [LEN_REG_W-1:0]    len_model = cs4bc_pkg::LEN_RESET;
    logic [ROW_REG_W-1:0]    rows_model = cs4bc_pkg::ROW_RESET;
    logic [LEN_REG_W-1:0]    gen_len = cs4bc_pkg::LEN_RESET;
    logic [ROW_REG_W-1:0]    gen_rows = cs4bc_pkg::ROW_RESET;
    int                      fail_count = 0;
    int                      quiet_cycles = 0;
    int                      gap_left = 0;
    int                      burst_left = 0;
    int                      cycle_count = 0;
    int                      stall_mode = 0;
    logic [7:0]              stall_phase = '0;
    logic [15:0]             stall_pattern = '1;

    circulant_strength4_balance_check_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // spread of the 16 tuple counts must stay within one for every 4-row subset
    function automatic logic predict_balanced(input logic [LEN_REG_W-1:0] len_reg,
                                              input logic [ROW_REG_W-1:0] rows_reg,
                                              input logic [IN_W-1:0] vec);
        int              n;
        int              k;
        int              lo;
        int              hi;
        int              cnt[TUPLES];
        logic [3:0]      tup;
        logic [LEN_CAP-1:0] row_bits[ROW_CAP];
        n = (len_reg > LEN_CAP) ? LEN_CAP : int'(len_reg);
        k = (rows_reg > ROW_CAP) ? ROW_CAP : int'(rows_reg);
        for (int s = 0; s < k; s++) begin
            row_bits[s] = '0;
            for (int j = 0; j < n; j++) begin
                row_bits[s][j] = vec[(j + s) % n];
            end
        end
        for (int a = 0; a < k; a++) begin
            for (int b = a + 1; b < k; b++) begin
                for (int c = b + 1; c < k; c++) begin
                    for (int d = c + 1; d < k; d++) begin
                        for (int t = 0; t < TUPLES; t++) cnt[t] = 0;
                        for (int j = 0; j < n; j++) begin
                            tup = {row_bits[a][j], row_bits[b][j],
                                   row_bits[c][j], row_bits[d][j]};
                            cnt[tup]++;
                        end
                        lo = cnt[0];
                        hi = cnt[0];
                        for (int t = 1; t < TUPLES; t++) begin
                            if (cnt[t] < lo) lo = cnt[t];
                            if (cnt[t] > hi) hi = cnt[t];
                        end
                        if (hi - lo > 1) return 1'b0;
                    end
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return 0;
            4, 5:       return $urandom_range(1, 8);
            6:          return $urandom_range(9, 60);
            default:    return $urandom_range(61, 400);
        endcase
    endfunction

    task automatic queue_item(input logic [IN_W-1:0] vec);
        t_pend p;
        p.kind    = PEND_ITEM;
        p.reg_idx = cs4bc_pkg::REG_VECTOR_LENGTH;
        p.value   = '0;
        p.vector  = vec;
        pending_q.insert(pending_q.size(), p);
    endtask

    task automatic queue_cfg(input cs4bc_pkg::t_reg_index idx, input logic [CFG_W-1:0] val);
        t_pend p;
        p.kind    = PEND_CFG;
        p.reg_idx = idx;
        p.value   = val;
        p.vector  = '0;
        pending_q.insert(pending_q.size(), p);
        if (idx == cs4bc_pkg::REG_VECTOR_LENGTH) gen_len = val;
        else gen_rows = val[ROW_REG_W-1:0];
    endtask

    task automatic queue_drain();
        t_pend p;
        p.kind    = PEND_DRAIN;
        p.reg_idx = cs4bc_pkg::REG_VECTOR_LENGTH;
        p.value   = '0;
        p.vector  = '0;
        pending_q.insert(pending_q.size(), p);
    endtask

    // random vector, biased toward passing ones when the check is cheap
    function automatic logic [IN_W-1:0] random_vector();
        logic [IN_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = IN_W'($urandom() & $urandom());
            1:       v = IN_W'($urandom() | $urandom());
            default: v = IN_W'($urandom());
        endcase
        if (gen_rows <= 8 && $urandom_range(0, 1)) begin
            for (int t = 0; t < 24; t++) begin
                if (predict_balanced(gen_len, gen_rows, v)) break;
                v = IN_W'($urandom());
            end
        end
        return v;
    endfunction

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("%0t: timeout, %0d results outstanding", $time, balance_exp_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        t_pend head_item;
        logic  vld_next;
        logic  we_next;
        vld_next = i_s_axis_tvalid;
        we_next  = 1'b0;
        if (!i_rst_n) begin
            vld_next     = 1'b0;
            quiet_cycles = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                balance_exp_q.insert(balance_exp_q.size(),
                                     predict_balanced(len_model, rows_model,
                                                      i_s_axis_tdata[IN_W-1:0]));
                vld_next = 1'b0;
            end
            if (balance_exp_q.size() == 0 && !vld_next) quiet_cycles++;
            else quiet_cycles = 0;
            if (!vld_next && pending_q.size() > 0) begin
                head_item = pending_q[0];
                case (head_item.kind)
                    PEND_ITEM: begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            vld_next = 1'b1;
                            i_s_axis_tdata <= head_item.vector;
                            void'(pending_q.pop_front());
                            if (burst_left > 0) begin
                                burst_left--;
                            end else begin
                                burst_left = $urandom_range(0, 7);
                                gap_left   = pick_gap();
                            end
                        end
                    end
                    PEND_CFG: begin
                        if (quiet_cycles >= SETTLE_CYCLES) begin
                            we_next = 1'b1;
                            i_cfg_index <= head_item.reg_idx;
                            i_cfg_data  <= head_item.value;
                            if (head_item.reg_idx == cs4bc_pkg::REG_VECTOR_LENGTH) begin
                                len_model = head_item.value;
                            end else begin
                                rows_model = head_item.value[ROW_REG_W-1:0];
                            end
                            void'(pending_q.pop_front());
                            quiet_cycles = 0;
                        end
                    end
                    default: begin
                        if (quiet_cycles >= 1) void'(pending_q.pop_front());
                    end
                endcase
            end
        end
        i_s_axis_tvalid <= vld_next;
        i_cfg_we        <= we_next;
    end

    // result stall pattern
    always @(posedge i_clk) begin
        logic rdy;
        stall_phase++;
        if (stall_phase[5:0] == 6'd0) begin
            stall_mode    = $urandom_range(0, 3);
            stall_pattern = 16'($urandom());
        end
        case (stall_mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            2:       rdy = stall_pattern[stall_phase[3:0]];
            default: rdy = (stall_phase[5:4] == 2'd3);
        endcase
        i_m_axis_tready <= rdy;
    end

    // monitor
    always @(posedge i_clk) begin
        logic exp_flag;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (balance_exp_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %0h",
                         $time, o_m_axis_tdata);
                fail_count++;
            end else begin
                exp_flag = balance_exp_q.pop_front();
                if (o_m_axis_tdata !== {{(OUT_TDATA_W-1){1'b0}}, exp_flag}) begin
                    $display("%0t: balanced mismatch, expected %0h actual %0h",
                             $time, {{(OUT_TDATA_W-1){1'b0}}, exp_flag}, o_m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int                   random_count;
        int                   phase_items;
        logic [LEN_REG_W-1:0] len_val;
        logic [ROW_REG_W-1:0] rows_val;

        // reset settings: n = 8, k = 10
        queue_item(24'h000000);
        queue_item(24'hFFFFFF);
        queue_item(24'hAAAAAA);
        queue_item(24'h555555);
        queue_item(24'h0000F0);
        // de Bruijn sequence of order 4 over four rows
        queue_cfg(cs4bc_pkg::REG_VECTOR_LENGTH, 5'd16);
        queue_cfg(cs4bc_pkg::REG_ROW_COUNT, 5'd4);
        queue_item(24'h00F590);
        queue_item(24'hFFF590);
        queue_item(24'h000000);
        // no columns at all
        queue_cfg(cs4bc_pkg::REG_VECTOR_LENGTH, 5'd0);
        queue_item(24'h123456);
        // both registers above their caps
        queue_cfg(cs4bc_pkg::REG_VECTOR_LENGTH, 5'd31);
        queue_cfg(cs4bc_pkg::REG_ROW_COUNT, 5'h1F);
        queue_item(24'hFFFFFF);
        queue_item(24'h000000);
        queue_item(IN_W'($urandom()));
        // fewer than four rows
        queue_cfg(cs4bc_pkg::REG_ROW_COUNT, 5'h13);
        queue_item(IN_W'($urandom()));
        queue_item(24'h000000);
        queue_cfg(cs4bc_pkg::REG_ROW_COUNT, 5'd0);
        queue_item(24'hFFFFFF);
        // more rows than columns
        queue_cfg(cs4bc_pkg::REG_VECTOR_LENGTH, 5'd4);
        queue_cfg(cs4bc_pkg::REG_ROW_COUNT, 5'd12);
        queue_item(24'h000005);
        queue_item(24'hFFFFFA);
        queue_item(24'h000003);
        queue_cfg(cs4bc_pkg::REG_VECTOR_LENGTH, 5'd25);
        queue_cfg(cs4bc_pkg::REG_ROW_COUNT, 5'd4);
        queue_item(24'h800000);

        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       len_val = LEN_REG_W'($urandom_range(0, 31));
                1:       len_val = LEN_REG_W'($urandom_range(17, 24));
                default: len_val = LEN_REG_W'($urandom_range(4, 16));
            endcase
            case ($urandom_range(0, 9))
                0:       rows_val = ROW_REG_W'($urandom_range(0, 15));
                1:       rows_val = ROW_REG_W'($urandom_range(9, 12));
                default: rows_val = ROW_REG_W'($urandom_range(4, 8));
            endcase
            if ($urandom_range(0, 1)) begin
                queue_cfg(cs4bc_pkg::REG_VECTOR_LENGTH, len_val);
                queue_cfg(cs4bc_pkg::REG_ROW_COUNT, {1'($urandom_range(0, 1)), rows_val});
            end else begin
                queue_cfg(cs4bc_pkg::REG_ROW_COUNT, {1'($urandom_range(0, 1)), rows_val});
                queue_cfg(cs4bc_pkg::REG_VECTOR_LENGTH, len_val);
            end
            phase_items = (gen_rows > 8) ? $urandom_range(5, 15) : $urandom_range(20, 60);
            for (int i = 0; i < phase_items; i++) begin
                queue_item(random_vector());
                random_count++;
                if ($urandom_range(0, 29) == 0) queue_drain();
            end
        end

        wait (i_rst_n);
        while (pending_q.size() > 0 || i_s_axis_tvalid || balance_exp_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (balance_exp_q.size() > 0) fail_count++;
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
